>>> src/assert_macros.svh
// Assertion macros used by the top level of the DDA circular interpolator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property held at every clock edge out of reset
`define ASSERT_HOLD(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequence in the cycle after the trigger
`define ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) else $error(msg);

`endif

>>> src/ddaci_pkg.sv
// Types and constants for the DDA circular interpolator
package ddaci_pkg;

  localparam int PT_W           = 16;
  localparam int RAD_W          = 15;
  localparam int CNT_W          = 18;
  localparam int ACC_W          = 20;
  localparam int CAP_W          = 13;
  localparam int COORD_BITS_DEF = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef struct packed {
    op_e                     opcode;
    logic signed [PT_W-1:0]  x_start;
    logic signed [PT_W-1:0]  y_start;
    logic signed [PT_W-1:0]  x_end;
    logic signed [PT_W-1:0]  y_end;
    logic [RAD_W-1:0]        radius;
  } in_t;

  typedef struct packed {
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    logic                   last;
  } out_t;

  // step counters, rates and accumulators of both axes
  typedef struct packed {
    logic [CNT_W-1:0] steps_x;
    logic [CNT_W-1:0] steps_y;
    logic [CNT_W-1:0] rate_x;
    logic [CNT_W-1:0] rate_y;
    logic [ACC_W-1:0] acc_x;
    logic [ACC_W-1:0] acc_y;
  } ctr_t;

endpackage

>>> src/ddaci_load.sv
// Arc setup: step counts, initial rates and start/target positions
module ddaci_load #(
  parameter int COORD_BITS = ddaci_pkg::COORD_BITS_DEF
) (
  input  ddaci_pkg::in_t                item_i,
  output ddaci_pkg::ctr_t               ctr_o,
  output logic signed [COORD_BITS-1:0]  pos_x_o,
  output logic signed [COORD_BITS-1:0]  pos_y_o,
  output logic signed [COORD_BITS-1:0]  tgt_x_o,
  output logic signed [COORD_BITS-1:0]  tgt_y_o
);

  localparam int W    = 19;
  localparam int CntW = ddaci_pkg::CNT_W;

  logic signed [W-1:0] xs, ys, xe, ye, r;
  logic signed [W-1:0] axs, ays, dx, dy, adx, ady;
  logic signed [W-1:0] cx, cy;

  assign xs = W'(item_i.x_start);
  assign ys = W'(item_i.y_start);
  assign xe = W'(item_i.x_end);
  assign ye = W'(item_i.y_end);
  assign r  = W'($signed({1'b0, item_i.radius}));

  assign axs = xs[W-1] ? -xs : xs;
  assign ays = ys[W-1] ? -ys : ys;
  assign dx  = xe - xs;
  assign dy  = ye - ys;
  assign adx = dx[W-1] ? -dx : dx;
  assign ady = dy[W-1] ? -dy : dy;

  always_comb begin
    if (dx != '0) begin
      cx = adx;
    end else if ((xs < 0 && ye > ys) || (xs > 0 && ye < ys)) begin
      cx = (r + axs) <<< 1;
    end else if ((xs < 0 && ye < ys) || (xs > 0 && ye > ys)) begin
      cx = (r - axs) <<< 1;
    end else begin
      cx = r <<< 2;
    end

    if (dy != '0) begin
      cy = ady;
    end else if ((ys < 0 && xe > xs) || (ys > 0 && xe < xs)) begin
      cy = (r - ays) <<< 1;
    end else if ((ys < 0 && xe < xs) || (ys > 0 && xe > xs)) begin
      cy = (r + ays) <<< 1;
    end else begin
      cy = r <<< 2;
    end
  end

  // counts never exceed the 18-bit range; only negatives clamp
  assign ctr_o.steps_x = cx[W-1] ? '0 : cx[CntW-1:0];
  assign ctr_o.steps_y = cy[W-1] ? '0 : cy[CntW-1:0];
  assign ctr_o.rate_x  = ays[CntW-1:0];
  assign ctr_o.rate_y  = axs[CntW-1:0];
  assign ctr_o.acc_x   = '0;
  assign ctr_o.acc_y   = '0;

  assign pos_x_o = COORD_BITS'(item_i.x_start);
  assign pos_y_o = COORD_BITS'(item_i.y_start);
  assign tgt_x_o = COORD_BITS'(item_i.x_end);
  assign tgt_y_o = COORD_BITS'(item_i.y_end);

endmodule

>>> src/ddaci_tick.sv
// One interpolation tick: accumulate, step, adjust cross rates, detect arc end
module ddaci_tick #(
  parameter int COORD_BITS = ddaci_pkg::COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0]    pos_x_i,
  input  logic signed [COORD_BITS-1:0]    pos_y_i,
  input  logic signed [COORD_BITS-1:0]    tgt_x_i,
  input  logic signed [COORD_BITS-1:0]    tgt_y_i,
  input  ddaci_pkg::ctr_t                 ctr_i,
  input  logic [ddaci_pkg::CAP_W-1:0]     cap_i,
  output logic signed [COORD_BITS-1:0]    pos_x_o,
  output logic signed [COORD_BITS-1:0]    pos_y_o,
  output ddaci_pkg::ctr_t                 ctr_o,
  output logic                            moved_o,
  output logic                            finish_o
);

  localparam int AccW = ddaci_pkg::ACC_W;

  typedef enum logic [1:0] {
    QUAD_1,
    QUAD_2,
    QUAD_3,
    QUAD_4
  } quad_e;

  quad_e            quad;
  logic             x_pos, x_neg, y_pos, y_neg, xy_zero;
  logic             x_dn, y_dn, ry_dn, rx_dn;
  logic             mx, my;
  logic [AccW-1:0]  sum_x, sum_y, cap_ext;

  assign x_neg   = pos_x_i[COORD_BITS-1];
  assign y_neg   = pos_y_i[COORD_BITS-1];
  assign x_pos   = !x_neg && (pos_x_i != '0);
  assign y_pos   = !y_neg && (pos_y_i != '0);
  assign xy_zero = (pos_x_i == '0) && (pos_y_i == '0);

  always_comb begin
    if ((x_pos && !y_neg) || xy_zero) begin
      quad = QUAD_1;
    end else if (!x_pos && y_pos) begin
      quad = QUAD_2;
    end else if (x_neg && !y_pos) begin
      quad = QUAD_3;
    end else begin
      quad = QUAD_4;
    end
  end

  assign x_dn  = (quad == QUAD_1) || (quad == QUAD_2);
  assign y_dn  = (quad == QUAD_2) || (quad == QUAD_3);
  assign ry_dn = (quad == QUAD_1) || (quad == QUAD_3);
  assign rx_dn = (quad == QUAD_2) || (quad == QUAD_4);

  assign cap_ext = AccW'(cap_i);
  assign sum_x   = ctr_i.acc_x + AccW'(ctr_i.rate_x);
  assign sum_y   = ctr_i.acc_y + AccW'(ctr_i.rate_y);

  always_comb begin
    ctr_o    = ctr_i;
    pos_x_o  = pos_x_i;
    pos_y_o  = pos_y_i;
    mx       = 1'b0;
    my       = 1'b0;
    finish_o = 1'b0;

    if (ctr_i.steps_x != '0) begin
      ctr_o.acc_x = sum_x;
      if (sum_x >= cap_ext) begin
        mx            = 1'b1;
        ctr_o.acc_x   = sum_x - cap_ext;
        ctr_o.steps_x = ctr_i.steps_x - 1'b1;
        pos_x_o       = x_dn ? pos_x_i - COORD_BITS'(1) : pos_x_i + COORD_BITS'(1);
      end
    end

    if (ctr_i.steps_y != '0) begin
      ctr_o.acc_y = sum_y;
      if (sum_y >= cap_ext) begin
        my            = 1'b1;
        ctr_o.acc_y   = sum_y - cap_ext;
        ctr_o.steps_y = ctr_i.steps_y - 1'b1;
        pos_y_o       = y_dn ? pos_y_i - COORD_BITS'(1) : pos_y_i + COORD_BITS'(1);
      end
    end else if (ctr_o.steps_x == '0) begin
      // both counts spent: snap to the target
      finish_o = 1'b1;
      pos_x_o  = tgt_x_i;
      pos_y_o  = tgt_y_i;
    end

    if (!finish_o) begin
      if (mx) begin
        if (ry_dn) begin
          ctr_o.rate_y = (ctr_i.rate_y == '0) ? '0 : ctr_i.rate_y - 1'b1;
        end else begin
          ctr_o.rate_y = (&ctr_i.rate_y) ? ctr_i.rate_y : ctr_i.rate_y + 1'b1;
        end
      end
      if (my) begin
        if (rx_dn) begin
          ctr_o.rate_x = (ctr_i.rate_x == '0) ? '0 : ctr_i.rate_x - 1'b1;
        end else begin
          ctr_o.rate_x = (&ctr_i.rate_x) ? ctr_i.rate_x : ctr_i.rate_x + 1'b1;
        end
      end
    end
  end

  assign moved_o = mx || my;

endmodule

>>> src/dda_circular_interpolator_top.sv
// Top level of the counter-clockwise DDA circular interpolator
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i): a load beat
//   (opcode OP_LOAD) starts an arc and always yields the start point; a
//   tick beat (OP_TICK) advances the running arc by one DDA step and yields
//   a point when either axis moved, or the end point with last set when
//   both step counts run out. Ticks while no arc runs yield nothing.
//   Output channel (out_valid_o / out_stall_i / out_item_o): one point per
//   result beat. Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i)
//   writes the accumulator capacity; it is always ready and is to be
//   written only while the block is idle.
// Timing: an input beat is captured in an input register, processed in
//   one pass of adds and compares, and any result lands in the output
//   register, which raises out_valid_o. One beat per cycle is sustained
//   while out_stall_i is low; the arc state registers close their loop in that one pass.
// Reset: no arc active, all counters zero, capacity 64.
// Stall: while the output register holds an untaken result and out_stall_i
//   is high, the input register cannot drain and in_stall_o rises once it
//   holds a beat; nothing is dropped.
module dda_circular_interpolator_top #(
  parameter int COORD_BITS = ddaci_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ddaci_pkg::in_t                in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ddaci_pkg::out_t               out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ddaci_pkg::CAP_W-1:0]   cfg_data_i
);

`include "assert_macros.svh"

  localparam int PtW = ddaci_pkg::PT_W;

  // input register
  logic            in_valid_q;
  ddaci_pkg::in_t  in_q;

  // arc state
  logic                          active_q, active_d;
  logic signed [COORD_BITS-1:0]  pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic signed [COORD_BITS-1:0]  tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  ddaci_pkg::ctr_t               ctr_q, ctr_d;
  logic [ddaci_pkg::CAP_W-1:0]   cap_q;

  // output register
  logic             out_valid_q;
  ddaci_pkg::out_t  out_q, res;

  // datapath results
  ddaci_pkg::ctr_t               ld_ctr, tk_ctr;
  logic signed [COORD_BITS-1:0]  ld_px, ld_py, ld_tx, ld_ty, tk_px, tk_py;
  logic                          tk_moved, tk_finish;

  logic adv, is_load, emit;

  ddaci_load #(.COORD_BITS(COORD_BITS)) u_load (
    .item_i  (in_q),
    .ctr_o   (ld_ctr),
    .pos_x_o (ld_px),
    .pos_y_o (ld_py),
    .tgt_x_o (ld_tx),
    .tgt_y_o (ld_ty)
  );

  ddaci_tick #(.COORD_BITS(COORD_BITS)) u_tick (
    .pos_x_i  (pos_x_q),
    .pos_y_i  (pos_y_q),
    .tgt_x_i  (tgt_x_q),
    .tgt_y_i  (tgt_y_q),
    .ctr_i    (ctr_q),
    .cap_i    (cap_q),
    .pos_x_o  (tk_px),
    .pos_y_o  (tk_py),
    .ctr_o    (tk_ctr),
    .moved_o  (tk_moved),
    .finish_o (tk_finish)
  );

  // the held beat is processed when the output slot is free or draining
  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign is_load    = (in_q.opcode == ddaci_pkg::OP_LOAD);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    active_d = active_q;
    pos_x_d  = pos_x_q;
    pos_y_d  = pos_y_q;
    tgt_x_d  = tgt_x_q;
    tgt_y_d  = tgt_y_q;
    ctr_d    = ctr_q;
    emit     = 1'b0;
    if (is_load) begin
      active_d = 1'b1;
      pos_x_d  = ld_px;
      pos_y_d  = ld_py;
      tgt_x_d  = ld_tx;
      tgt_y_d  = ld_ty;
      ctr_d    = ld_ctr;
      emit     = 1'b1;
    end else if (active_q) begin
      active_d = !tk_finish;
      pos_x_d  = tk_px;
      pos_y_d  = tk_py;
      ctr_d    = tk_ctr;
      emit     = tk_moved || tk_finish;
    end
  end

  assign res.point_x = PtW'(pos_x_d);
  assign res.point_y = PtW'(pos_y_d);
  assign res.last    = !is_load && tk_finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      active_q    <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      tgt_x_q     <= '0;
      tgt_y_q     <= '0;
      ctr_q       <= '0;
      cap_q       <= ddaci_pkg::CAP_RESET;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end

      if (adv && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (adv) begin
        active_q <= active_d;
        pos_x_q  <= pos_x_d;
        pos_y_q  <= pos_y_d;
        tgt_x_q  <= tgt_x_d;
        tgt_y_q  <= tgt_y_d;
        ctr_q    <= ctr_d;
      end

      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_item_i;
    end
    if (adv && emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `ASSERT_NEXT(a_load_emits, adv && is_load, out_valid_o && !out_item_o.last, "load gave no start point")
  `ASSERT_NEXT(a_idle_tick_quiet, adv && !is_load && !active_q && !out_valid_o, !out_valid_o, "tick while idle gave a point")
  `ASSERT_NEXT(a_last_ends_arc, adv && emit && res.last, !active_q, "arc still active after end point")
  `ASSERT_HOLD(a_start_by_load, $rose(active_q) |-> $past(adv && is_load), "arc started without a load")

endmodule
